FILE: hw/rtl/sha256_hash_engine_core_macros.svh
// Assertion macros shared by the SHA-256 core RTL.
`ifndef SHA256_HASH_ENGINE_CORE_MACROS_SVH
`define SHA256_HASH_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 core: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 core: next-cycle check failed");

`endif

FILE: hw/rtl/sha_pkg.sv
// Package with SHA-256 types, round constants and sequencer codes.
package sha_pkg;

    // Input operation codes
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINAL  = 1'b1;

    // Sequencer limits
    localparam logic [5:0] LAST_BYTE   = 6'd63;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [5:0] LAST_DIRECT = 6'd15;
    localparam logic [2:0] LAST_WORD   = 3'd7;
    localparam logic [7:0] PAD_MARK    = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Working variables a..h of the compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } sha_work_t;

    // Schedule window taps feeding the next message word
    typedef struct packed {
        logic        direct;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w9;
        logic [31:0] w14;
    } sha_taps_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } sha_state_t;

endpackage

FILE: hw/rtl/sha_stream_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface sha_msg_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface sha_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

FILE: hw/rtl/sha_round.sv
// Shared SHA-256 round unit: one compression round and one schedule step.
module sha_round
    import sha_pkg::*;
(
    input  sha_work_t   work,
    input  logic [31:0] w_cur,
    input  logic [31:0] k_cur,
    input  sha_taps_t   taps,
    output sha_work_t   work_next,
    output logic [31:0] w_next
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sig0;
    logic [31:0] sig1;

    // Round function
    assign big1 = rotr(work.e, 6) ^ rotr(work.e, 11) ^ rotr(work.e, 25);
    assign big0 = rotr(work.a, 2) ^ rotr(work.a, 13) ^ rotr(work.a, 22);
    assign ch   = (work.e & work.f) ^ (~work.e & work.g);
    assign maj  = (work.a & work.b) ^ (work.a & work.c) ^ (work.b & work.c);
    assign t1   = work.h + big1 + ch + k_cur + w_cur;
    assign t2   = big0 + maj;

    always_comb
    begin
        work_next.h = work.g;
        work_next.g = work.f;
        work_next.f = work.e;
        work_next.e = work.d + t1;
        work_next.d = work.c;
        work_next.c = work.b;
        work_next.b = work.a;
        work_next.a = t1 + t2;
    end

    // Message schedule: pass a block word through, or expand from the window
    assign sig0   = rotr(taps.w1, 7) ^ rotr(taps.w1, 18) ^ (taps.w1 >> 3);
    assign sig1   = rotr(taps.w14, 17) ^ rotr(taps.w14, 19) ^ (taps.w14 >> 10);
    assign w_next = taps.direct ? taps.w0 : (sig1 + taps.w9 + sig0 + taps.w0);

endmodule

FILE: hw/rtl/sha256_hash_engine_core.sv
// SHA-256 core: byte absorb, padding, iterative compression and digest output.
// Absorb: one byte per cycle while idle; every 64th byte starts a compression (load, 64 rounds, fold).
// No bytes are taken while a block is compressed; the shared unit does one round per cycle.
// Finalize: padding bytes at 1 per cycle, then one or two compressions,
// then 8 digest transfers, each of which can be stalled by the output.
// Async active-low reset loads the initial hash values and clears all counters.
`include "sha256_hash_engine_core_macros.svh"

module sha256_hash_engine_core
    import sha_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sha_msg_if.sink             msg,
    sha_digest_if.source        digest
);

    sha_state_t  state_reg;
    sha_state_t  state_next;
    logic [5:0]  byte_cnt_reg;
    logic [54:0] blk_cnt_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        pad_reg;
    logic        final_reg;
    logic        first_reg;
    logic [31:0] chain_reg [8];

    logic [63:0] len_reg;
    logic [31:0] sched_reg [16];
    logic [31:0] w_reg;
    sha_work_t   work_reg;

    logic        msg_fire;
    logic        out_fire;
    logic        absorb_fire;
    logic        final_fire;
    logic        len_phase;
    logic        shift_en;
    logic [7:0]  shift_byte;
    sha_taps_t   taps;
    sha_work_t   work_next;
    logic [31:0] w_next;

    // Handshakes
    assign msg.ready   = (state_reg == ST_IDLE);
    assign msg_fire    = msg.valid && msg.ready;
    assign absorb_fire = msg_fire && (msg.op == OP_ABSORB);
    assign final_fire  = msg_fire && (msg.op == OP_FINAL);

    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = chain_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last        = (idx_reg == LAST_WORD);
    assign out_fire           = digest.valid && digest.ready;

    // Padding byte source: marker, zeros, then big-endian length
    assign len_phase  = final_reg && !first_reg && (byte_cnt_reg >= LEN_POS);
    assign shift_en   = absorb_fire || (state_reg == ST_PAD);
    assign shift_byte = (state_reg == ST_PAD)
                        ? (first_reg ? PAD_MARK : (len_phase ? len_reg[63:56] : 8'h00))
                        : msg.data_byte;

    // Shared round unit
    assign taps.direct = (round_reg < LAST_DIRECT);
    assign taps.w0     = sched_reg[0];
    assign taps.w1     = sched_reg[1];
    assign taps.w9     = sched_reg[9];
    assign taps.w14    = sched_reg[14];

    sha_round u_round (
        .work      (work_reg),
        .w_cur     (w_reg),
        .k_cur     (ROUND_K[round_reg]),
        .taps      (taps),
        .work_next (work_next),
        .w_next    (w_next)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (final_fire)
                    state_next = ST_PAD;
                else if (absorb_fire && (byte_cnt_reg == LAST_BYTE))
                    state_next = ST_LOAD;
            end
            ST_PAD:
            begin
                if (byte_cnt_reg == LAST_BYTE)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                priority if (!pad_reg)
                    state_next = ST_IDLE;
                else if (!final_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire && (idx_reg == LAST_WORD))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            byte_cnt_reg <= '0;
            blk_cnt_reg  <= '0;
            round_reg    <= '0;
            idx_reg      <= '0;
            pad_reg      <= 1'b0;
            final_reg    <= 1'b0;
            first_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            state_reg <= state_next;

            // Advance byte position on every byte written into the window
            if (shift_en)
                byte_cnt_reg <= byte_cnt_reg + 6'd1;

            if (absorb_fire && (byte_cnt_reg == LAST_BYTE))
                blk_cnt_reg <= blk_cnt_reg + 55'd1;

            if (final_fire)
            begin
                pad_reg   <= 1'b1;
                final_reg <= (byte_cnt_reg < LEN_POS);
                first_reg <= 1'b1;
            end
            else if (state_reg == ST_PAD)
                first_reg <= 1'b0;

            if ((state_reg == ST_FOLD) && pad_reg && !final_reg)
                final_reg <= 1'b1;

            if (state_reg == ST_ROUND)
                round_reg <= round_reg + 6'd1;

            if (state_reg == ST_FOLD)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[(7 - i) * 32 +: 32];
            end

            // Drop the message state after the last digest transfer
            if (out_fire)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == LAST_WORD)
                begin
                    blk_cnt_reg <= '0;
                    pad_reg     <= 1'b0;
                    final_reg   <= 1'b0;
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= INIT_HASH[i];
                end
            end
        end
    end

    // Datapath: message window, length shifter, working variables
    always_ff @(posedge clk)
    begin
        if (final_fire)
            len_reg <= {blk_cnt_reg, byte_cnt_reg, 3'b000};
        else if ((state_reg == ST_PAD) && len_phase)
            len_reg <= {len_reg[55:0], 8'h00};

        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= {sched_reg[i][23:0], sched_reg[i + 1][31:24]};
            sched_reg[15] <= {sched_reg[15][23:0], shift_byte};
        end
        else if ((state_reg == ST_LOAD) || (state_reg == ST_ROUND))
        begin
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= w_next;
            w_reg         <= w_next;
        end

        if (state_reg == ST_LOAD)
            work_reg <= {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3],
                         chain_reg[4], chain_reg[5], chain_reg[6], chain_reg[7]};
        else if (state_reg == ST_ROUND)
            work_reg <= work_next;
    end

    // Checks
    `SHA_ASSERT_NOW(a_no_input_while_output, digest.valid, !msg.ready)
    `SHA_ASSERT_NOW(a_round_cnt_idle, (state_reg != ST_ROUND), (round_reg == 6'd0))
    `SHA_ASSERT_NEXT(a_fold_to_output, (state_reg == ST_FOLD) && pad_reg && final_reg,
                     digest.valid && (digest.word_index == 3'd0))
    `SHA_ASSERT_NEXT(a_last_restarts, out_fire && digest.last,
                     msg.ready && (byte_cnt_reg == 6'd0) && (chain_reg[0] == INIT_HASH[0]))

endmodule

FILE: dv/sha256_digest_checker.sv
`timescale 1ns / 1ps
// Checker for the SHA-256 core: watches both channels, predicts digests and compares them.
module sha256_digest_checker
    import sha_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sha_msg_if    msg,
    sha_digest_if digest,
    output int    mismatch_count,
    output int    words_pending
);

    localparam int         BLOCK_BYTES = 64;
    localparam int         LEN_POS     = 56;
    localparam int         DIGEST_LEN  = 8;
    localparam logic [7:0] PAD_MARK    = 8'h80;

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } hash_word_t;

    // Predicted hash state
    logic [31:0] chain_h [8];
    logic [7:0]  msg_block [BLOCK_BYTES];
    logic [5:0]  fill;
    logic [63:0] bit_total;

    hash_word_t digest_words_due [$];
    hash_word_t due_word;
    int         error_total;
    int         pad_pos;
    int         k;
    logic [63:0] bit_len;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the 64-byte block into the chaining value
    function automatic void sha_fold_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, w2, w15;
        int r;
        for (r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                sched[r] = {msg_block[4 * r], msg_block[4 * r + 1],
                            msg_block[4 * r + 2], msg_block[4 * r + 3]};
            end
            else
            begin
                w2  = sched[r - 2];
                w15 = sched[r - 15];
                sched[r] = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + sched[r - 7]
                         + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + sched[r - 16];
            end
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        f = chain_h[5];
        g = chain_h[6];
        h = chain_h[7];
        for (r = 0; r < 64; r++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + SHA_K[r] + sched[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
        chain_h[5] = chain_h[5] + f;
        chain_h[6] = chain_h[6] + g;
        chain_h[7] = chain_h[7] + h;
    endfunction

    // Start a fresh message
    function automatic void restart_message();
        chain_h   = SHA_H0;
        fill      = 6'd0;
        bit_total = 64'd0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            digest_words_due.delete();
            error_total = 0;
            mismatch_count <= 0;
            words_pending  <= 0;
        end
        else
        begin
            // Predict on each byte-channel transfer
            if (msg.valid && msg.ready)
            begin
                if (msg.op == OP_ABSORB)
                begin
                    msg_block[fill] = msg.data_byte;
                    fill = fill + 6'd1;
                    if (fill == 6'd0)
                    begin
                        sha_fold_block();
                        bit_total = bit_total + 64'd512;
                    end
                end
                else
                begin
                    pad_pos = int'(fill);
                    bit_len = bit_total + 64'(pad_pos) * 64'd8;
                    msg_block[pad_pos] = PAD_MARK;
                    for (k = pad_pos + 1; k < BLOCK_BYTES; k++)
                        msg_block[k] = 8'h00;
                    // No room for the length: spill into a second block
                    if (pad_pos >= LEN_POS)
                    begin
                        sha_fold_block();
                        for (k = 0; k < LEN_POS; k++)
                            msg_block[k] = 8'h00;
                    end
                    for (k = 0; k < 8; k++)
                        msg_block[LEN_POS + k] = bit_len[63 - 8 * k -: 8];
                    sha_fold_block();
                    for (k = 0; k < DIGEST_LEN; k++)
                    begin
                        digest_words_due.push_back('{digest_word: chain_h[k],
                                                     word_index: 3'(k),
                                                     last: (k == DIGEST_LEN - 1)});
                    end
                    restart_message();
                end
            end

            // Compare each digest transfer against the oldest prediction
            if (digest.valid && digest.ready)
            begin
                if (digest_words_due.size() == 0)
                begin
                    $error("digest_word: expected none, actual %08h", digest.digest_word);
                    error_total++;
                end
                else
                begin
                    due_word = digest_words_due.pop_front();
                    if (digest.digest_word !== due_word.digest_word)
                    begin
                        $error("digest_word: expected %08h, actual %08h",
                               due_word.digest_word, digest.digest_word);
                        error_total++;
                    end
                    if (digest.word_index !== due_word.word_index)
                    begin
                        $error("word_index: expected %0d, actual %0d",
                               due_word.word_index, digest.word_index);
                        error_total++;
                    end
                    if (digest.last !== due_word.last)
                    begin
                        $error("last: expected %0b, actual %0b", due_word.last, digest.last);
                        error_total++;
                    end
                end
            end

            mismatch_count <= error_total;
            words_pending  <= digest_words_due.size();
        end
    end

endmodule

FILE: dv/tb_sha256_hash_engine_core.sv
`timescale 1ns / 1ps
// Testbench top for the SHA-256 core: clock, reset, byte stimulus, digest sink and verdict.
module tb_sha256_hash_engine_core
    import sha_pkg::*;
();

    localparam int ITEM_TARGET  = 210;
    localparam int MAX_PAUSE    = 17;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 256;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatch_count;
    int words_pending;
    int items_sent  = 0;
    int send_burst  = 0;
    int recv_burst  = 0;
    int idle_cycles = 0;

    sha_msg_if    msg_ch ();
    sha_digest_if digest_ch ();

    sha256_hash_engine_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    sha256_digest_checker digest_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg            (msg_ch),
        .digest         (digest_ch),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Draw a pause length; now and then open a stretch with no pauses
    function automatic int draw_pause(inout int burst);
        int pause;
        pause = 0;
        if (burst > 0)
            burst--;
        else if ($urandom_range(0, 7) == 0)
            burst = $urandom_range(8, 30);
        else
            pause = $urandom_range(0, MAX_PAUSE);
        return pause;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic op, input logic [7:0] data);
        int pause;
        pause = draw_pause(send_burst);
        if (pause > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.op        <= op;
        msg_ch.data_byte <= data;
        do
            @(posedge clk);
        while (!(msg_ch.valid && msg_ch.ready));
        items_sent++;
    endtask

    // Absorb a random message of the given length, then finalize it
    task automatic send_message(input int len);
        int n;
        for (n = 0; n < len; n++)
        begin
            send_item(OP_ABSORB, ($urandom_range(0, 5) == 0)
                      ? {8{1'($urandom_range(0, 1))}} : 8'($urandom_range(0, 255)));
        end
        send_item(OP_FINAL, 8'($urandom_range(0, 255)));
    endtask

    // Digest sink with random stalls
    initial
    begin
        int stall;
        digest_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_pause(recv_burst);
            if (stall > 0)
            begin
                digest_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            digest_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(digest_ch.valid && digest_ch.ready));
        end
    end

    // Stimulus and verdict
    initial
    begin
        int len;
        msg_ch.valid     = 1'b0;
        msg_ch.op        = OP_ABSORB;
        msg_ch.data_byte = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty message
        send_item(OP_FINAL, 8'h00);
        // "abc", with a data byte on finalize that must be ignored
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_FINAL, 8'hff);
        // Byte extremes and a byte equal to the pad mark
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_ABSORB, 8'h80);
        send_item(OP_FINAL, 8'h5a);
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_FINAL, 8'h00);

        // Random messages, with lengths around the padding and block edges
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                7:       len = 55 + $urandom_range(0, 1);
                8:       len = 63 + $urandom_range(0, 2);
                9:       len = $urandom_range(13, 54);
                default: len = $urandom_range(0, 12);
            endcase
            send_message(len);
        end
        msg_ch.valid <= 1'b0;

        // Drain the outstanding digests, then let the core settle
        do
            @(posedge clk);
        while (words_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("sha256_hash_engine_core: match");
        else
            $display("sha256_hash_engine_core: mismatch");
        $finish;
    end

    // Watchdog: end the run after too long without any transfer
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((msg_ch.valid && msg_ch.ready) || (digest_ch.valid && digest_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sha256_hash_engine_core: mismatch");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sha_pkg.sv
hw/rtl/sha_stream_if.sv
hw/rtl/sha_round.sv
hw/rtl/sha256_hash_engine_core.sv
dv/sha256_digest_checker.sv
dv/tb_sha256_hash_engine_core.sv
